[hw/rtl/gif_frame_compositor_unit_defines.svh]
// assertion macros for the compositor
`ifndef GIF_FRAME_COMPOSITOR_UNIT_DEFINES_SVH
`define GIF_FRAME_COMPOSITOR_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define GFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/gfc_pkg.sv]
package gfc_pkg;
  typedef enum logic [2:0] {
    FUNC_PAL   = 3'd0,
    FUNC_BEGIN = 3'd1,
    FUNC_PIXEL = 3'd2,
    FUNC_READ  = 3'd3,
    FUNC_END   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    DISP_KEEP    = 2'd0,
    DISP_CLEAR   = 2'd1,
    DISP_RESTORE = 2'd2
  } disp_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_OUT,
    ST_SAVE,
    ST_RESTORE,
    ST_CLEAR
  } state_e;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
endpackage

[hw/rtl/gfc_mem.sv]
// single-port-write, single-port-read memory with registered read data
module gfc_mem #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

[hw/rtl/gif_frame_compositor_unit.sv]
// a canvas read answers through the canvas read register, then out_q, in state ST_OUT
// throughput: one pixel or palette word per cycle unless a read or canvas walk stalls input
// frame begin of a nonempty frame with restore disposal copies the canvas to the snapshot
// frame end of an active frame walks the canvas for clear or restore
// after reset a clearing pass zeroes the whole canvas;
// no word is accepted meanwhile, configuration writes are taken
module gif_frame_compositor_unit
  import gfc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[2:0], color_index[10:3], red[18:11], green[26:19], blue[34:27], pos_x[50:35],
  // pos_y[66:51], size_w[82:67], size_h[98:83], transparency_on[99],
  // transparent_index[107:100], disposal[109:108], zero[111:110]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [8:0]   cfg_data_i
);
  localparam int unsigned XW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW = XW + YW;
  localparam int unsigned CELLS = 1 << AW;
  localparam int unsigned PW = $clog2(PALETTE_SIZE);

  // field unpacking
  logic [2:0]  f_func;
  logic [7:0]  f_cidx, f_r, f_g, f_b, f_tidx;
  logic [15:0] f_px, f_py, f_sw, f_sh;
  logic        f_ton;
  logic [1:0]  f_disp;
  assign f_func = s_axis_tdata[2:0];
  assign f_cidx = s_axis_tdata[10:3];
  assign f_r    = s_axis_tdata[18:11];
  assign f_g    = s_axis_tdata[26:19];
  assign f_b    = s_axis_tdata[34:27];
  assign f_px   = s_axis_tdata[50:35];
  assign f_py   = s_axis_tdata[66:51];
  assign f_sw   = s_axis_tdata[82:67];
  assign f_sh   = s_axis_tdata[98:83];
  assign f_ton  = s_axis_tdata[99];
  assign f_tidx = s_axis_tdata[107:100];
  assign f_disp = s_axis_tdata[109:108];

  // configuration
  logic [8:0] cw_q, ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q <= 9'd256;
      ch_q <= 9'd256;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_WIDTH) cw_q <= cfg_data_i;
      if (cfg_index_i == REG_HEIGHT) ch_q <= cfg_data_i;
    end
  end
  logic [12:0] ew, eh;
  assign ew = ({4'd0, cw_q} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, cw_q};
  assign eh = ({4'd0, ch_q} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, ch_q};

  // frame state
  state_e      state_q, state_d;
  logic [15:0] ox_q, oy_q, fw_q, fh_q, col_q, row_q;
  logic        act_q, ton_q;
  logic [7:0]  tidx_q;
  logic [1:0]  disp_q;
  logic [AW:0] sw_q, sw_d;          // sweep counter
  logic [31:0] out_q;
  logic [AW-1:0] rd_addr_q;
  logic        rd_ok_q;
  logic        rd_fwd_q;
  logic [31:0] rd_fwd_data_q;
  logic [31:0] rd_word;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = out_q;

  // pixel target with clipping
  logic [16:0] tx, ty;
  logic        pix_in, pix_do;
  assign tx = {1'b0, ox_q} + {1'b0, col_q};
  assign ty = {1'b0, oy_q} + {1'b0, row_q};
  assign pix_in = (tx < {4'd0, ew}) && (ty < {4'd0, eh});
  assign pix_do = act_q && (row_q < fh_q);

  // palette memory
  logic          pal_we;
  logic [23:0]   pal_rd;
  logic [PW-1:0] pal_ra;
  assign pal_we = acc && (f_func == FUNC_PAL) && ({1'b0, f_cidx} < 9'(PALETTE_SIZE));
  assign pal_ra = f_cidx[PW-1:0];
  gfc_mem #(.Depth(1 << PW), .Width(24)) u_pal (
    .clk_i, .we_i(pal_we), .waddr_i(f_cidx[PW-1:0]), .wdata_i({f_r, f_g, f_b}),
    .raddr_i(pal_ra), .rdata_o(pal_rd)
  );

  // pixel write stage: palette data arrives in the cycle after the pixel word is taken
  logic          pw_q, pw_black_q;
  logic [AW-1:0] pw_addr_q;

  // canvas and snapshot memories
  logic          cv_we, sv_we;
  logic [AW-1:0] cv_wa, cv_ra, sv_ra;
  logic [31:0]   cv_wd, cv_rd, sv_rd;
  gfc_mem #(.Depth(CELLS), .Width(32)) u_canvas (
    .clk_i, .we_i(cv_we), .waddr_i(cv_wa), .wdata_i(cv_wd),
    .raddr_i(cv_ra), .rdata_o(cv_rd)
  );
  gfc_mem #(.Depth(CELLS), .Width(32)) u_saved (
    .clk_i, .we_i(sv_we), .waddr_i(sw_q[AW:1] == '0 ? sw_q[AW-1:0] - AW'(1)
                                    : sw_q[AW-1:0] - AW'(1)),
    .wdata_i(cv_rd), .raddr_i(sv_ra), .rdata_o(sv_rd)
  );

  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  assign sx = sw_q[XW-1:0];
  assign sy = sw_q[AW-1:XW];
  logic [16:0] sx_w, sy_w;
  assign sx_w = 17'(sx);
  assign sy_w = 17'(sy);
  logic clr_hit;
  assign clr_hit = (sx_w >= {1'b0, ox_q}) && (sy_w >= {1'b0, oy_q})
                && (sx_w < {1'b0, ox_q} + {1'b0, fw_q}) && (sx_w < {4'd0, ew})
                && (sy_w < {1'b0, oy_q} + {1'b0, fh_q}) && (sy_w < {4'd0, eh});

  // memory port control and next state
  always_comb begin
    state_d = state_q;
    sw_d    = sw_q;
    cv_we   = 1'b0;
    cv_wa   = sw_q[AW-1:0];
    cv_wd   = '0;
    cv_ra   = sw_q[AW-1:0];
    sv_we   = 1'b0;
    sv_ra   = sw_q[AW-1:0];
    if (pw_q) begin
      cv_we = 1'b1;
      cv_wa = pw_addr_q;
      cv_wd = pw_black_q ? {24'd0, ALPHA_OPAQUE} : {pal_rd, ALPHA_OPAQUE};
    end
    case (state_q)
      ST_INIT: begin
        cv_we = 1'b1;
        cv_wd = '0;
        sw_d  = sw_q + 1'b1;
        if (sw_q[AW-1:0] == AW'(CELLS - 1)) begin
          sw_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (f_func)
            FUNC_READ: state_d = ST_READ;
            FUNC_BEGIN: begin
              sw_d = '0;
              if (f_sw != 0 && f_sh != 0 && f_disp == DISP_RESTORE) state_d = ST_SAVE;
            end
            FUNC_END: begin
              sw_d = '0;
              if (act_q && disp_q == DISP_CLEAR) state_d = ST_CLEAR;
              if (act_q && disp_q == DISP_RESTORE) state_d = ST_RESTORE;
            end
            default: ;
          endcase
        end
        cv_ra = rd_addr_q;
        if (acc && f_func == FUNC_READ) cv_ra = {f_py[YW-1:0], f_px[XW-1:0]};
      end
      ST_READ: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
      ST_SAVE: begin
        // canvas read at sw, snapshot written in the following cycle
        sv_we = (sw_q != 0);
        sw_d  = sw_q + 1'b1;
        if (sw_q == (AW+1)'(CELLS)) state_d = ST_IDLE;
      end
      ST_RESTORE: begin
        sv_ra = sw_q[AW-1:0];
        if (sw_q != 0) begin
          cv_we = 1'b1;
          cv_wa = sw_q[AW-1:0] - AW'(1);
          cv_wd = sv_rd;
        end
        sw_d = sw_q + 1'b1;
        if (sw_q == (AW+1)'(CELLS)) state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        cv_we = clr_hit;
        cv_wd = '0;
        sw_d  = sw_q + 1'b1;
        if (sw_q[AW-1:0] == AW'(CELLS - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sw_q    <= '0;
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
    end
  end

  // a pixel written in the read's acceptance cycle is forwarded
  assign rd_word = rd_fwd_q ? rd_fwd_data_q : cv_rd;

  // read capture
  always_ff @(posedge clk_i) begin
    if (acc && f_func == FUNC_READ) begin
      rd_addr_q     <= {f_py[YW-1:0], f_px[XW-1:0]};
      rd_ok_q       <= ({1'b0, f_px} < {4'd0, ew}) && ({1'b0, f_py} < {4'd0, eh});
      rd_fwd_q      <= cv_we && (cv_wa == {f_py[YW-1:0], f_px[XW-1:0]});
      rd_fwd_data_q <= cv_wd;
    end
    if (state_q == ST_READ) begin
      out_q <= rd_ok_q ? {rd_word[7:0], rd_word[15:8], rd_word[23:16], rd_word[31:24]} : '0;
    end
  end

  // frame registers and pixel stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0; oy_q <= '0; fw_q <= '0; fh_q <= '0;
      col_q <= '0; row_q <= '0;
      act_q <= 1'b0; ton_q <= 1'b0; tidx_q <= '0; disp_q <= '0;
      pw_q <= 1'b0; pw_black_q <= 1'b0; pw_addr_q <= '0;
    end else begin
      pw_q <= 1'b0;
      if (acc) begin
        case (f_func)
          FUNC_BEGIN: begin
            ox_q <= f_px; oy_q <= f_py; fw_q <= f_sw; fh_q <= f_sh;
            col_q <= '0; row_q <= '0;
            act_q  <= (f_sw != 0) && (f_sh != 0);
            ton_q  <= f_ton && (f_sw != 0) && (f_sh != 0);
            tidx_q <= ((f_sw != 0) && (f_sh != 0)) ? f_tidx : 8'd0;
            disp_q <= ((f_sw != 0) && (f_sh != 0)) ? f_disp : 2'd0;
          end
          FUNC_PIXEL: begin
            if (pix_do) begin
              pw_q       <= pix_in && !(ton_q && f_cidx == tidx_q);
              pw_black_q <= ({1'b0, f_cidx} >= 9'(PALETTE_SIZE));
              pw_addr_q  <= {ty[YW-1:0], tx[XW-1:0]};
              if (col_q + 16'd1 >= fw_q) begin
                col_q <= '0;
                row_q <= row_q + 16'd1;
              end else begin
                col_q <= col_q + 16'd1;
              end
            end
          end
          FUNC_END: begin
            act_q <= 1'b0; ton_q <= 1'b0; tidx_q <= '0;
            col_q <= '0; row_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

[hw/rtl/gfc_checker.sv]
`include "gif_frame_compositor_unit_defines.svh"
// port-level checks
module gfc_checker
  import gfc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_func_i,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  logic s_acc, m_stall;
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // only a read gives a result word
  `GFC_ASSERT_NEXT(a_res_src, clk_i, rst_ni, s_acc && s_func_i != FUNC_READ, !m_axis_tvalid)
  // no input taken while a result is pending
  `GFC_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // result held while stalled
  `GFC_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_stall, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind gif_frame_compositor_unit gfc_checker u_gfc_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_func_i(s_axis_tdata[2:0]),
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

[tb/tb_gif_frame_compositor_unit.sv]
module tb_gif_frame_compositor_unit;
  import gfc_pkg::*;

  localparam int unsigned CANVAS_W = 256;
  localparam int unsigned CANVAS_H = 256;
  localparam int unsigned CELLS    = CANVAS_W * CANVAS_H;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned PALETTE_SIZE_TB = 256;
  // codes the block ignores or treats as keep
  localparam logic [1:0] DISP_UNUSED   = 2'd3;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [7:0]  cidx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic        ton;
    logic [7:0]  tidx;
    logic [1:0]  disp;
  } word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [8:0]   cfg_data_i;

  gif_frame_compositor_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // compositor state as the testbench sees it
  logic [23:0] pal_rgb [PALETTE_SIZE_TB];
  bit          pal_written [256];
  logic [31:0] canvas_px [CELLS];
  logic [31:0] snapshot_px [CELLS];
  int unsigned scr_w, scr_h;
  int unsigned org_x, org_y, frm_w, frm_h, col_pos, row_pos;
  bit          frm_active, frm_ton;
  logic [7:0]  frm_tidx;
  logic [1:0]  frm_disp;

  rgba_t       pixel_reads_due [$];
  int unsigned mismatches;
  int unsigned words_sent;
  bit          src_burst, sink_burst;
  int unsigned clears_left, restores_left;

  function automatic int unsigned vis_w();
    return (scr_w > CANVAS_W) ? CANVAS_W : scr_w;
  endfunction

  function automatic int unsigned vis_h();
    return (scr_h > CANVAS_H) ? CANVAS_H : scr_h;
  endfunction

  // update the canvas picture for one accepted word
  task automatic composite_word(input word_t w);
    int unsigned x, y, x1, y1;
    rgba_t       res;
    logic [31:0] v;
    case (w.func)
      FUNC_PAL: begin
        pal_rgb[w.cidx]     = {w.red, w.green, w.blue};
        pal_written[w.cidx] = 1'b1;
      end
      FUNC_BEGIN: begin
        frm_active = 1'b0;
        col_pos    = 0;
        row_pos    = 0;
        org_x      = w.pos_x;
        org_y      = w.pos_y;
        frm_w      = w.size_w;
        frm_h      = w.size_h;
        if (w.size_w != 0 && w.size_h != 0) begin
          frm_active = 1'b1;
          frm_ton    = w.ton;
          frm_tidx   = w.tidx;
          frm_disp   = w.disp;
          if (w.disp == DISP_RESTORE) snapshot_px = canvas_px;
        end
      end
      FUNC_PIXEL: begin
        if (frm_active && row_pos < frm_h) begin
          x = org_x + col_pos;
          y = org_y + row_pos;
          if (x < vis_w() && y < vis_h() && !(frm_ton && w.cidx == frm_tidx))
            canvas_px[y * CANVAS_W + x] = {pal_rgb[w.cidx], ALPHA_OPAQUE};
          col_pos++;
          if (col_pos >= frm_w) begin
            col_pos = 0;
            row_pos++;
          end
        end
      end
      FUNC_READ: begin
        v = '0;
        if (w.pos_x < vis_w() && w.pos_y < vis_h()) v = canvas_px[w.pos_y * CANVAS_W + w.pos_x];
        res.red   = v[31:24];
        res.green = v[23:16];
        res.blue  = v[15:8];
        res.alpha = v[7:0];
        pixel_reads_due = {pixel_reads_due, res};
      end
      FUNC_END: begin
        if (frm_active) begin
          if (frm_disp == DISP_CLEAR) begin
            x1 = (org_x + frm_w > vis_w()) ? vis_w() : org_x + frm_w;
            y1 = (org_y + frm_h > vis_h()) ? vis_h() : org_y + frm_h;
            for (y = org_y; y < y1; y++)
              for (x = org_x; x < x1; x++) canvas_px[y * CANVAS_W + x] = '0;
          end else if (frm_disp == DISP_RESTORE) begin
            canvas_px = snapshot_px;
          end
        end
        frm_active = 1'b0;
        col_pos    = 0;
        row_pos    = 0;
      end
      default: ;
    endcase
  endtask

  // send one word with a random gap, then predict it once accepted
  task automatic send_word(input word_t w);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, w.disp, w.tidx, w.ton, w.size_h, w.size_w, w.pos_y, w.pos_x,
                     w.blue, w.green, w.red, w.cidx, w.func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    composite_word(w);
    words_sent++;
    if ($urandom_range(0, 99) == 0) src_burst = ~src_burst;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // word with junk in every field the function does not use
  function automatic word_t junk_word(input logic [2:0] func);
    word_t w;
    w.func   = func;
    w.cidx   = 8'($urandom);
    w.red    = 8'($urandom);
    w.green  = 8'($urandom);
    w.blue   = 8'($urandom);
    w.pos_x  = 16'($urandom);
    w.pos_y  = 16'($urandom);
    w.size_w = 16'($urandom);
    w.size_h = 16'($urandom);
    w.ton    = 1'($urandom);
    w.tidx   = 8'($urandom);
    w.disp   = 2'($urandom);
    return w;
  endfunction

  task automatic send_pal(input int unsigned idx, input logic [23:0] rgb);
    word_t w;
    w = junk_word(FUNC_PAL);
    w.cidx = 8'(idx);
    {w.red, w.green, w.blue} = rgb;
    send_word(w);
  endtask

  task automatic send_begin(input int unsigned x, y, fw, fh, input bit ton,
                            input int unsigned tidx, input logic [1:0] disp);
    word_t w;
    w = junk_word(FUNC_BEGIN);
    w.pos_x  = 16'(x);
    w.pos_y  = 16'(y);
    w.size_w = 16'(fw);
    w.size_h = 16'(fh);
    w.ton    = ton;
    w.tidx   = 8'(tidx);
    w.disp   = disp;
    send_word(w);
  endtask

  task automatic send_pixel(input int unsigned idx);
    word_t w;
    w = junk_word(FUNC_PIXEL);
    w.cidx = 8'(idx);
    send_word(w);
  endtask

  task automatic send_read(input int unsigned x, y);
    word_t w;
    w = junk_word(FUNC_READ);
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    send_word(w);
  endtask

  task automatic send_end();
    send_word(junk_word(FUNC_END));
  endtask

  // a colour index whose palette entry holds a known value
  function automatic int unsigned written_index();
    int unsigned idx;
    repeat (64) begin
      idx = $urandom_range(0, 255);
      if (pal_written[idx]) return idx;
    end
    for (idx = 0; idx < 256; idx++) if (pal_written[idx]) return idx;
    return 0;
  endfunction

  // wait until every read has answered; a read also waits out any canvas walk
  task automatic drain();
    send_read(0, 0);
    stop_sending();
    while (pixel_reads_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [8:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = reg_idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (reg_idx == REG_WIDTH) scr_w = val;
    else scr_h = val;
  endtask

  task automatic set_screen(input logic [8:0] sw, sh);
    drain();
    write_reg(REG_WIDTH, sw);
    write_reg(REG_HEIGHT, sh);
  endtask

  // result sink with random stalls
  bit taken;
  always @(posedge clk_i) begin
    rgba_t exp_px;
    taken = m_axis_tvalid && m_axis_tready;
    if (rst_ni && taken) begin
      if (pixel_reads_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        exp_px = pixel_reads_due.pop_front();
        if (m_axis_tdata !== {exp_px.alpha, exp_px.blue, exp_px.green, exp_px.red}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                     m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                     m_axis_tdata[31:24]);
        end
      end
    end
  end

  int unsigned stall_left;
  always @(negedge clk_i) begin
    if (taken) begin
      if ($urandom_range(0, 49) == 0) sink_burst = ~sink_burst;
      stall_left = sink_burst ? 0 : $urandom_range(0, 8);
    end
    if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // palette extremes and a spread of entries
  task automatic test_palette();
    send_pal(0, 24'h000000);
    send_pal(255, 24'hffffff);
    send_pal(1, 24'hff00ff);
    send_pal(2, 24'h00ff00);
    send_pal(3, 24'h123456);
  endtask

  // register extremes: zero and oversize screens clip or saturate
  task automatic test_screen_size();
    set_screen(9'd0, 9'd0);
    send_begin(0, 0, 2, 1, 1'b0, 0, DISP_KEEP);
    send_pixel(1);
    send_pixel(2);
    send_end();
    set_screen(9'd511, 9'd511);
    send_read(0, 0);
    send_read(255, 255);
    send_read(256, 0);
    send_read(65535, 65535);
    set_screen(9'd1, 9'd1);
  endtask

  // odd frame sequences and ignored words
  task automatic test_special_frames();
    set_screen(9'd16, 9'd16);
    send_pixel(1);
    send_end();
    send_begin(3, 3, 0, 5, 1'b0, 0, DISP_CLEAR);
    send_pixel(2);
    send_end();
    send_begin(0, 0, 2, 1, 1'b1, 2, DISP_UNUSED);
    send_pixel(1);
    send_pixel(2);
    send_pixel(3);
    send_begin(14, 15, 3, 2, 1'b1, 3, DISP_KEEP);
    repeat (6) send_pixel(255);
    send_end();
    send_word(junk_word(FUNC_SPARE_LO));
    send_word(junk_word(FUNC_SPARE_HI));
    send_read(0, 0);
    send_read(15, 15);
  endtask

  // clear-rectangle and restore-previous disposal
  task automatic test_disposal();
    send_begin(2, 2, 2, 2, 1'b0, 0, DISP_RESTORE);
    repeat (4) send_pixel(3);
    send_read(3, 3);
    send_end();
    send_read(3, 3);
    send_begin(14, 0, 65535, 2, 1'b0, 0, DISP_CLEAR);
    send_pixel(255);
    send_end();
    send_read(14, 0);
  endtask

  // random frames with random content, some broken and some noise
  task automatic test_random_frames();
    int unsigned kind, target, npix, fw, fh, ox, oy, tidx, i;
    logic [1:0]  disp;
    bit          pressed;
    pressed = 1'b0;
    target  = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_pal($urandom_range(0, 255), 24'($urandom));
      end else if (kind < 12) begin
        if ($urandom_range(0, 1))
          send_word(junk_word(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI))));
        else send_read($urandom, $urandom);
      end else if (kind < 14) begin
        if ($urandom_range(0, 3) == 0) set_screen(9'($urandom), 9'($urandom));
        else set_screen(9'($urandom_range(1, 40)), 9'($urandom_range(1, 40)));
      end else begin
        if (!pressed && words_sent > target - RANDOM_WORDS / 2) begin
          drain();
          pressed = 1'b1;
        end
        fw = $urandom_range(1, 8);
        fh = $urandom_range(1, 6);
        ox = $urandom_range(0, vis_w() + 2);
        oy = $urandom_range(0, vis_h() + 2);
        case ($urandom_range(0, 19))
          0: fw = 0;
          1: fh = 0;
          2: begin
            fw = $urandom_range(0, 65535);
            fh = $urandom_range(0, 65535);
            ox = $urandom_range(0, 65535);
            oy = $urandom_range(0, 65535);
          end
          default: ;
        endcase
        disp = $urandom_range(0, 1) ? DISP_KEEP : DISP_UNUSED;
        if (clears_left != 0 && $urandom_range(0, 9) == 0) begin
          disp = DISP_CLEAR;
          clears_left--;
        end else if (restores_left != 0 && $urandom_range(0, 29) == 0) begin
          disp = DISP_RESTORE;
          restores_left--;
        end
        tidx = $urandom_range(0, 3) != 0 ? written_index() : $urandom_range(0, 255);
        send_begin(ox, oy, fw, fh, 1'($urandom_range(0, 1)), tidx, disp);
        npix = (fw * fh > 40) ? 40 : fw * fh;
        npix = npix + $urandom_range(0, 2) - ((npix != 0 && $urandom_range(0, 9) == 0) ? 1 : 0);
        for (i = 0; i < npix; i++) begin
          // only entries with a known colour are drawn
          send_pixel((($urandom_range(0, 3) == 0) && pal_written[tidx]) ? tidx
                                                                         : written_index());
          if ($urandom_range(0, 5) == 0)
            send_read(ox + $urandom_range(0, fw), oy + $urandom_range(0, fh));
        end
        // a broken frame is abandoned without its end
        if ($urandom_range(0, 9) != 0) send_end();
        repeat ($urandom_range(1, 3))
          send_read(ox + $urandom_range(0, fw + 1), oy + $urandom_range(0, fh + 1));
      end
    end
  endtask

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_WIDTH;
    cfg_data_i    = '0;
    words_sent    = 0;
    src_burst     = 1'b0;
    clears_left   = 6;
    restores_left = 2;
    for (n = 0; n < 256; n++) begin
      pal_rgb[n]     = '0;
      pal_written[n] = 1'b0;
    end
    for (n = 0; n < CELLS; n++) canvas_px[n] = '0;
    scr_w = 256;
    scr_h = 256;
    org_x = 0; org_y = 0; frm_w = 0; frm_h = 0;
    col_pos = 0; row_pos = 0;
    frm_active = 1'b0; frm_ton = 1'b0; frm_tidx = '0; frm_disp = DISP_KEEP;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_palette();
    test_screen_size();
    test_special_frames();
    test_disposal();
    test_random_frames();

    stop_sending();
    while (pixel_reads_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
